>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset disable
`define PFCI_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Invariant that holds at every enabled edge
`define PFCI_ASSERT_INV(lbl, clk, rst, expr, msg) \
   `PFCI_ASSERT_CLK(lbl, clk, rst, expr, msg)

`endif

>>> design/pfci_pkg.sv
// ----------------------------------------------------------------------------
// pfci_pkg
// Widths, codes, shared types and helpers of the cone isolation sum block.
// ----------------------------------------------------------------------------
package pfci_pkg;

   // Field widths
   localparam int PT_BITS   = 16;
   localparam int ANG_W     = 11;
   localparam int DIFF_W    = ANG_W + 1;
   localparam int SQ_W      = 2 * ANG_W;
   localparam int KIND_W    = 2;
   localparam int ACC_W     = 24;
   localparam int REL_W     = 16;
   localparam int DR2_W     = 23;
   localparam int CUT_W     = 16;
   localparam int CMP_W     = (PT_BITS > CUT_W) ? PT_BITS : CUT_W;
   localparam int SUM_W     = ((PT_BITS > ACC_W) ? PT_BITS : ACC_W) + 1;

   // Relative isolation scale and divider sizing
   localparam int REL_SHIFT = 10;
   localparam int NUM_W     = ACC_W + REL_SHIFT;
   localparam int LIM_W     = (NUM_W > PT_BITS + REL_W) ? NUM_W : PT_BITS + REL_W;
   localparam int DIV_CNT_W = $clog2(REL_W);

   // Saturation limits
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam logic [REL_W-1:0] REL_MAX = {REL_W{1'b1}};

   // Azimuth wrap, in angle units
   localparam int PHI_HALF = 720;
   localparam int PHI_FULL = 1440;

   // Particle kinds
   localparam logic [KIND_W-1:0] KIND_CHG   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NEU   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PHO   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

   // Input opcodes
   localparam logic OPC_LOAD     = 1'b0;
   localparam logic OPC_PARTICLE = 1'b1;

   // Queue operation codes, front to back
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
   localparam logic [OP_W-1:0] OP_SKIP  = 3'd1;
   localparam logic [OP_W-1:0] OP_CHG   = 3'd2;
   localparam logic [OP_W-1:0] OP_NEU   = 3'd3;
   localparam logic [OP_W-1:0] OP_PHO   = 3'd4;
   localparam logic [OP_W-1:0] OP_PU    = 3'd5;

   // Queue sizing
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_CONE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHG_VETO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEU_VETO    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHG_PT_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEU_PT_MIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PU_PT_MIN   = 3'd5;

   // Register reset values
   localparam logic [DR2_W-1:0] CONE_RST     = 23'd8464;
   localparam logic [DR2_W-1:0] CHG_VETO_RST = 23'd0;
   localparam logic [DR2_W-1:0] NEU_VETO_RST = 23'd5;
   localparam logic [CUT_W-1:0] CHG_MIN_RST  = 16'd0;
   localparam logic [CUT_W-1:0] NEU_MIN_RST  = 16'd2;
   localparam logic [CUT_W-1:0] PU_MIN_RST   = 16'd2;

   // Cut settings seen by the front
   typedef struct packed {
      logic [DR2_W-1:0] cone_dr2;
      logic [DR2_W-1:0] charged_veto_dr2;
      logic [DR2_W-1:0] neutral_veto_dr2;
      logic [CUT_W-1:0] charged_pt_min;
      logic [CUT_W-1:0] neutral_pt_min;
      logic [CUT_W-1:0] pileup_pt_min;
   } cfg_type;

   // One classified item in the queue
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [PT_BITS-1:0] pt;
      logic               last;
   } qent_type;

   // Saturating accumulate of one pt value
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [PT_BITS-1:0] pt);
      logic [SUM_W-1:0] s;
      s = SUM_W'(acc) + SUM_W'(pt);
      sat_add = (s > SUM_W'(ACC_MAX)) ? ACC_MAX : ACC_W'(s);
   endfunction

endpackage

>>> design/pfci_front.sv
// ----------------------------------------------------------------------------
// pfci_front
// Accepts items, forms the squared distance to the reference and classifies
// each particle into the sum it feeds, then writes it to the queue.
// ----------------------------------------------------------------------------
module pfci_front (
   input  logic                              clock,
   input  logic                              reset,
   input  pfci_pkg::cfg_type                 cfg,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_opcode,
   input  logic [pfci_pkg::PT_BITS-1:0]      req_pt,
   input  logic signed [pfci_pkg::ANG_W-1:0] req_eta,
   input  logic signed [pfci_pkg::ANG_W-1:0] req_phi,
   input  logic [pfci_pkg::KIND_W-1:0]       req_kind,
   input  logic                              req_from_pileup,
   input  logic                              req_last,
   input  logic                              q_full,
   output logic                              q_wr,
   output pfci_pkg::qent_type                q_wr_data
);

   // Reference direction
   logic signed [pfci_pkg::ANG_W-1:0] ref_eta_ff, ref_eta_in;
   logic signed [pfci_pkg::ANG_W-1:0] ref_phi_ff, ref_phi_in;

   // Stage 1: absolute angle differences
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_opcode_ff, s1_opcode_in;
   logic [pfci_pkg::PT_BITS-1:0]   s1_pt_ff, s1_pt_in;
   logic [pfci_pkg::KIND_W-1:0]    s1_kind_ff, s1_kind_in;
   logic                           s1_pu_ff, s1_pu_in;
   logic                           s1_last_ff, s1_last_in;
   logic [pfci_pkg::ANG_W-1:0]     s1_ae_ff, s1_ae_in;
   logic [pfci_pkg::ANG_W-1:0]     s1_ap_ff, s1_ap_in;

   // Stage 2: squared distance
   logic                           s2_valid_ff, s2_valid_in;
   logic                           s2_opcode_ff, s2_opcode_in;
   logic [pfci_pkg::PT_BITS-1:0]   s2_pt_ff, s2_pt_in;
   logic [pfci_pkg::KIND_W-1:0]    s2_kind_ff, s2_kind_in;
   logic                           s2_pu_ff, s2_pu_in;
   logic                           s2_last_ff, s2_last_in;
   logic [pfci_pkg::DR2_W-1:0]     s2_d2_ff, s2_d2_in;

   logic accept, s1_take, s1_out, s2_take, s2_out;
   logic signed [pfci_pkg::DIFF_W-1:0] de, dp_raw, dp;
   logic [pfci_pkg::SQ_W-1:0] sq_e, sq_p;
   logic in_cone, out_cveto, out_nveto;
   logic pt_chg, pt_neu, pt_pu;
   logic [pfci_pkg::OP_W-1:0] cls_op;

   // Pipeline flow control, stalled from the queue
   assign s2_out  = s2_valid_ff && !q_full;
   assign s2_take = !s2_valid_ff || s2_out;
   assign s1_out  = s1_valid_ff && s2_take;
   assign s1_take = !s1_valid_ff || s1_out;
   assign full    = !s1_take;
   assign accept  = push && s1_take;

   // Angle differences, azimuth wrapped into [-720, 719]
   always_comb begin
      de     = {req_eta[pfci_pkg::ANG_W-1], req_eta}
             - {ref_eta_ff[pfci_pkg::ANG_W-1], ref_eta_ff};
      dp_raw = {req_phi[pfci_pkg::ANG_W-1], req_phi}
             - {ref_phi_ff[pfci_pkg::ANG_W-1], ref_phi_ff};
      if (dp_raw >= $signed(pfci_pkg::DIFF_W'(pfci_pkg::PHI_HALF))) begin
         dp = dp_raw - $signed(pfci_pkg::DIFF_W'(pfci_pkg::PHI_FULL));
      end else if (dp_raw < -$signed(pfci_pkg::DIFF_W'(pfci_pkg::PHI_HALF))) begin
         dp = dp_raw + $signed(pfci_pkg::DIFF_W'(pfci_pkg::PHI_FULL));
      end else begin
         dp = dp_raw;
      end
   end

   // Stage 1 load and reference update
   always_comb begin
      ref_eta_in   = ref_eta_ff;
      ref_phi_in   = ref_phi_ff;
      s1_valid_in  = s1_valid_ff && !s1_out;
      s1_opcode_in = s1_opcode_ff;
      s1_pt_in     = s1_pt_ff;
      s1_kind_in   = s1_kind_ff;
      s1_pu_in     = s1_pu_ff;
      s1_last_in   = s1_last_ff;
      s1_ae_in     = s1_ae_ff;
      s1_ap_in     = s1_ap_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_opcode_in = req_opcode;
         s1_pt_in     = req_pt;
         s1_kind_in   = req_kind;
         s1_pu_in     = req_from_pileup;
         s1_last_in   = req_last;
         s1_ae_in     = de[pfci_pkg::DIFF_W-1] ? pfci_pkg::ANG_W'(-de)
                                               : pfci_pkg::ANG_W'(de);
         s1_ap_in     = dp[pfci_pkg::DIFF_W-1] ? pfci_pkg::ANG_W'(-dp)
                                               : pfci_pkg::ANG_W'(dp);
         if (req_opcode == pfci_pkg::OPC_LOAD) begin
            ref_eta_in = req_eta;
            ref_phi_in = req_phi;
         end
      end
   end

   // Stage 2: squares and their sum
   always_comb begin
      sq_e         = pfci_pkg::SQ_W'(s1_ae_ff) * pfci_pkg::SQ_W'(s1_ae_ff);
      sq_p         = pfci_pkg::SQ_W'(s1_ap_ff) * pfci_pkg::SQ_W'(s1_ap_ff);
      s2_valid_in  = s2_valid_ff && !s2_out;
      s2_opcode_in = s2_opcode_ff;
      s2_pt_in     = s2_pt_ff;
      s2_kind_in   = s2_kind_ff;
      s2_pu_in     = s2_pu_ff;
      s2_last_in   = s2_last_ff;
      s2_d2_in     = s2_d2_ff;
      if (s1_out) begin
         s2_valid_in  = 1'b1;
         s2_opcode_in = s1_opcode_ff;
         s2_pt_in     = s1_pt_ff;
         s2_kind_in   = s1_kind_ff;
         s2_pu_in     = s1_pu_ff;
         s2_last_in   = s1_last_ff;
         s2_d2_in     = pfci_pkg::DR2_W'(sq_e) + pfci_pkg::DR2_W'(sq_p);
      end
   end

   // Classification against cone, vetoes and pt cuts
   always_comb begin
      in_cone   = s2_d2_ff < cfg.cone_dr2;
      out_cveto = s2_d2_ff > cfg.charged_veto_dr2;
      out_nveto = s2_d2_ff > cfg.neutral_veto_dr2;
      pt_chg    = pfci_pkg::CMP_W'(s2_pt_ff) > pfci_pkg::CMP_W'(cfg.charged_pt_min);
      pt_neu    = pfci_pkg::CMP_W'(s2_pt_ff) > pfci_pkg::CMP_W'(cfg.neutral_pt_min);
      pt_pu     = pfci_pkg::CMP_W'(s2_pt_ff) > pfci_pkg::CMP_W'(cfg.pileup_pt_min);
      cls_op    = pfci_pkg::OP_SKIP;
      if (s2_opcode_ff == pfci_pkg::OPC_LOAD) begin
         cls_op = pfci_pkg::OP_CLEAR;
      end else if (in_cone) begin
         if (s2_pu_ff) begin
            if (s2_kind_ff == pfci_pkg::KIND_CHG && pt_pu && out_nveto) begin
               cls_op = pfci_pkg::OP_PU;
            end
         end else begin
            case (s2_kind_ff)
               pfci_pkg::KIND_CHG: if (pt_chg && out_cveto) cls_op = pfci_pkg::OP_CHG;
               pfci_pkg::KIND_NEU: if (pt_neu && out_nveto) cls_op = pfci_pkg::OP_NEU;
               pfci_pkg::KIND_PHO: if (pt_neu && out_nveto) cls_op = pfci_pkg::OP_PHO;
               default:            cls_op = pfci_pkg::OP_SKIP;
            endcase
         end
      end
   end

   // Queue write
   assign q_wr           = s2_out;
   assign q_wr_data.op   = cls_op;
   assign q_wr_data.pt   = s2_pt_ff;
   assign q_wr_data.last = (s2_opcode_ff == pfci_pkg::OPC_PARTICLE) && s2_last_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         ref_eta_ff  <= '0;
         ref_phi_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         ref_eta_ff  <= ref_eta_in;
         ref_phi_ff  <= ref_phi_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_opcode_ff <= s1_opcode_in;
      s1_pt_ff     <= s1_pt_in;
      s1_kind_ff   <= s1_kind_in;
      s1_pu_ff     <= s1_pu_in;
      s1_last_ff   <= s1_last_in;
      s1_ae_ff     <= s1_ae_in;
      s1_ap_ff     <= s1_ap_in;
      s2_opcode_ff <= s2_opcode_in;
      s2_pt_ff     <= s2_pt_in;
      s2_kind_ff   <= s2_kind_in;
      s2_pu_ff     <= s2_pu_in;
      s2_last_ff   <= s2_last_in;
      s2_d2_ff     <= s2_d2_in;
   end

endmodule

>>> design/pfci_queue.sv
// ----------------------------------------------------------------------------
// pfci_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfci_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  pfci_pkg::qent_type wr_data,
   output logic               full,
   output logic               rd_valid,
   input  logic               rd_en,
   output pfci_pkg::qent_type rd_data
);

   pfci_pkg::qent_type entry_ff [pfci_pkg::Q_DEPTH];
   logic [pfci_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pfci_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pfci_pkg::Q_CNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign full     = count_ff == pfci_pkg::Q_CNT_W'(pfci_pkg::Q_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `PFCI_ASSERT_INV(a_q_count_bound, clock, reset, count_ff <= pfci_pkg::Q_CNT_W'(pfci_pkg::Q_DEPTH), "queue fill count above depth")

endmodule

>>> design/pfci_back.sv
// ----------------------------------------------------------------------------
// pfci_back
// Applies queued items to the four sums and, on a last particle, forms the
// corrected isolation and its ratio to the reference pt in a result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfci_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  pfci_pkg::qent_type              q_rd_data,
   output logic                            q_rd,
   output logic                            empty,
   input  logic                            pop,
   output logic [pfci_pkg::ACC_W-1:0]      rsp_abs_iso,
   output logic [pfci_pkg::REL_W-1:0]      rsp_rel_iso,
   output logic [pfci_pkg::ACC_W-1:0]      rsp_charged_total,
   output logic [pfci_pkg::ACC_W-1:0]      rsp_neutral_total,
   output logic [pfci_pkg::ACC_W-1:0]      rsp_pileup_total
);

   // Sequencer states
   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_SUB   = 3'd1;
   localparam logic [2:0] ST_ABS   = 3'd2;
   localparam logic [2:0] ST_CHK   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;

   logic [2:0] state_ff, state_in;

   // Reference pt and sums
   logic [pfci_pkg::PT_BITS-1:0] ref_pt_ff, ref_pt_in;
   logic [pfci_pkg::ACC_W-1:0]   charged_acc_ff, charged_acc_in;
   logic [pfci_pkg::ACC_W-1:0]   neutral_acc_ff, neutral_acc_in;
   logic [pfci_pkg::ACC_W-1:0]   photon_acc_ff, photon_acc_in;
   logic [pfci_pkg::ACC_W-1:0]   pileup_acc_ff, pileup_acc_in;

   // Result working registers
   logic [pfci_pkg::ACC_W:0]     corr_ff, corr_in;
   logic [pfci_pkg::ACC_W-1:0]   np_sat_ff, np_sat_in;
   logic [pfci_pkg::ACC_W-1:0]   abs_ff, abs_in;
   logic                         sat_ff, sat_in;
   logic [pfci_pkg::PT_BITS-1:0] rem_ff, rem_in;
   logic [pfci_pkg::REL_W-1:0]   low_ff, low_in;
   logic [pfci_pkg::REL_W-1:0]   quo_ff, quo_in;
   logic [pfci_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // Result register
   logic                         out_valid_ff, out_valid_in;
   logic [pfci_pkg::ACC_W-1:0]   out_abs_ff, out_abs_in;
   logic [pfci_pkg::REL_W-1:0]   out_rel_ff, out_rel_in;
   logic [pfci_pkg::ACC_W-1:0]   out_chg_ff, out_chg_in;
   logic [pfci_pkg::ACC_W-1:0]   out_neu_ff, out_neu_in;
   logic [pfci_pkg::ACC_W-1:0]   out_pu_ff, out_pu_in;

   logic [pfci_pkg::ACC_W:0]     np, half;
   logic [pfci_pkg::ACC_W+1:0]   abs_sum;
   logic [pfci_pkg::NUM_W-1:0]   num;
   logic [pfci_pkg::PT_BITS:0]   trial;
   logic                         out_pop, out_free;

   assign q_rd     = q_valid && (state_ff == ST_RUN);
   assign out_pop  = pop && out_valid_ff;
   assign out_free = !out_valid_ff || out_pop;

   always_comb begin
      state_in       = state_ff;
      ref_pt_in      = ref_pt_ff;
      charged_acc_in = charged_acc_ff;
      neutral_acc_in = neutral_acc_ff;
      photon_acc_in  = photon_acc_ff;
      pileup_acc_in  = pileup_acc_ff;
      corr_in        = corr_ff;
      np_sat_in      = np_sat_ff;
      abs_in         = abs_ff;
      sat_in         = sat_ff;
      rem_in         = rem_ff;
      low_in         = low_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      out_valid_in   = out_valid_ff && !out_pop;
      out_abs_in     = out_abs_ff;
      out_rel_in     = out_rel_ff;
      out_chg_in     = out_chg_ff;
      out_neu_in     = out_neu_ff;
      out_pu_in      = out_pu_ff;

      np      = (pfci_pkg::ACC_W+1)'(neutral_acc_ff) + (pfci_pkg::ACC_W+1)'(photon_acc_ff);
      half    = (pfci_pkg::ACC_W+1)'(pileup_acc_ff >> 1);
      abs_sum = (pfci_pkg::ACC_W+2)'(charged_acc_ff) + (pfci_pkg::ACC_W+2)'(corr_ff);
      num     = {abs_ff, {pfci_pkg::REL_SHIFT{1'b0}}};
      trial   = {rem_ff, low_ff[pfci_pkg::REL_W-1]};

      unique case (state_ff)
         // Apply queued items to the sums
         ST_RUN: begin
            if (q_rd) begin
               case (q_rd_data.op)
                  pfci_pkg::OP_CLEAR: begin
                     ref_pt_in      = q_rd_data.pt;
                     charged_acc_in = '0;
                     neutral_acc_in = '0;
                     photon_acc_in  = '0;
                     pileup_acc_in  = '0;
                  end
                  pfci_pkg::OP_CHG:
                     charged_acc_in = pfci_pkg::sat_add(charged_acc_ff, q_rd_data.pt);
                  pfci_pkg::OP_NEU:
                     neutral_acc_in = pfci_pkg::sat_add(neutral_acc_ff, q_rd_data.pt);
                  pfci_pkg::OP_PHO:
                     photon_acc_in  = pfci_pkg::sat_add(photon_acc_ff, q_rd_data.pt);
                  pfci_pkg::OP_PU:
                     pileup_acc_in  = pfci_pkg::sat_add(pileup_acc_ff, q_rd_data.pt);
                  default: ;
               endcase
               if (q_rd_data.last) begin
                  state_in = ST_SUB;
               end
            end
         end
         // Neutral plus photon, less half the pileup, floored at zero
         ST_SUB: begin
            corr_in   = (np > half) ? np - half : '0;
            np_sat_in = (np > (pfci_pkg::ACC_W+1)'(pfci_pkg::ACC_MAX))
                      ? pfci_pkg::ACC_MAX : pfci_pkg::ACC_W'(np);
            state_in  = ST_ABS;
         end
         // Add the charged sum, saturating
         ST_ABS: begin
            abs_in   = (abs_sum > (pfci_pkg::ACC_W+2)'(pfci_pkg::ACC_MAX))
                     ? pfci_pkg::ACC_MAX : pfci_pkg::ACC_W'(abs_sum);
            state_in = ST_CHK;
         end
         // Quotient overflow check (also covers a zero reference pt)
         ST_CHK: begin
            sat_in = pfci_pkg::LIM_W'(num)
                  >= pfci_pkg::LIM_W'({ref_pt_ff, {pfci_pkg::REL_W{1'b0}}});
            rem_in = pfci_pkg::PT_BITS'(num >> pfci_pkg::REL_W);
            low_in = num[pfci_pkg::REL_W-1:0];
            quo_in = '0;
            cnt_in = '0;
            state_in = sat_in ? ST_WRITE : ST_DIV;
         end
         // Restoring division, one quotient bit a cycle
         ST_DIV: begin
            if (trial >= {1'b0, ref_pt_ff}) begin
               rem_in = pfci_pkg::PT_BITS'(trial - {1'b0, ref_pt_ff});
               quo_in = {quo_ff[pfci_pkg::REL_W-2:0], 1'b1};
            end else begin
               rem_in = pfci_pkg::PT_BITS'(trial);
               quo_in = {quo_ff[pfci_pkg::REL_W-2:0], 1'b0};
            end
            low_in = low_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pfci_pkg::DIV_CNT_W'(pfci_pkg::REL_W - 1)) begin
               state_in = ST_WRITE;
            end
         end
         // Load the result register once it is free
         ST_WRITE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_abs_in   = abs_ff;
               out_rel_in   = sat_ff ? pfci_pkg::REL_MAX : quo_ff;
               out_chg_in   = charged_acc_ff;
               out_neu_in   = np_sat_ff;
               out_pu_in    = pileup_acc_ff;
               state_in     = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // Control state and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         out_valid_ff   <= 1'b0;
         ref_pt_ff      <= '0;
         charged_acc_ff <= '0;
         neutral_acc_ff <= '0;
         photon_acc_ff  <= '0;
         pileup_acc_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         out_valid_ff   <= out_valid_in;
         ref_pt_ff      <= ref_pt_in;
         charged_acc_ff <= charged_acc_in;
         neutral_acc_ff <= neutral_acc_in;
         photon_acc_ff  <= photon_acc_in;
         pileup_acc_ff  <= pileup_acc_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      corr_ff    <= corr_in;
      np_sat_ff  <= np_sat_in;
      abs_ff     <= abs_in;
      sat_ff     <= sat_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      out_abs_ff <= out_abs_in;
      out_rel_ff <= out_rel_in;
      out_chg_ff <= out_chg_in;
      out_neu_ff <= out_neu_in;
      out_pu_ff  <= out_pu_in;
   end

   assign empty             = !out_valid_ff;
   assign rsp_abs_iso       = out_abs_ff;
   assign rsp_rel_iso       = out_rel_ff;
   assign rsp_charged_total = out_chg_ff;
   assign rsp_neutral_total = out_neu_ff;
   assign rsp_pileup_total  = out_pu_ff;

   `PFCI_ASSERT_CLK(a_sums_hold, clock, reset, (state_ff != ST_RUN) |=> ($stable(charged_acc_ff) && $stable(pileup_acc_ff)), "sums changed while forming a result")
   `PFCI_ASSERT_CLK(a_result_held, clock, reset, (out_valid_ff && !pop) |=> (out_valid_ff && $stable(out_abs_ff) && $stable(out_rel_ff)), "waiting result overwritten")
   `PFCI_ASSERT_INV(a_div_rem_bound, clock, reset, (state_ff != ST_DIV) || (rem_ff < ref_pt_ff), "divider remainder not below divisor")

endmodule

>>> design/pf_cone_isolation_sum.sv
// ----------------------------------------------------------------------------
// pf_cone_isolation_sum
// Delta-beta corrected particle-flow cone isolation around a reference object.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle while full is low: a two-stage front
// forms the squared angular distance and classifies the particle, then writes
// it into a four-entry queue. The back drains that queue at one item per cycle
// into four saturating sums when not forming a result, so particles stream at
// full rate. A particle marked last makes the back stop draining while it
// corrects the sums, checks the ratio for overflow, runs the bit-serial
// divider (skipped when the ratio saturates) and writes the result, which then
// waits in an output register while the back carries on. While the back is
// busy the queue and front fill, and full rises after about six further items.
// Registers must be written over the APB port only while no item is in flight;
// the block itself does not enforce this.

module pf_cone_isolation_sum (
   input  logic                                    clock,
   input  logic                                    reset,
   // Input queue side
   input  logic                                    push,
   output logic                                    full,
   input  logic                                    req_opcode,
   input  logic [pfci_pkg::PT_BITS-1:0]            req_pt,
   input  logic signed [pfci_pkg::ANG_W-1:0]       req_eta,
   input  logic signed [pfci_pkg::ANG_W-1:0]       req_phi,
   input  logic [pfci_pkg::KIND_W-1:0]             req_kind,
   input  logic                                    req_from_pileup,
   input  logic                                    req_last,
   // Result queue side
   output logic                                    empty,
   input  logic                                    pop,
   output logic [pfci_pkg::ACC_W-1:0]              rsp_abs_iso,
   output logic [pfci_pkg::REL_W-1:0]              rsp_rel_iso,
   output logic [pfci_pkg::ACC_W-1:0]              rsp_charged_total,
   output logic [pfci_pkg::ACC_W-1:0]              rsp_neutral_total,
   output logic [pfci_pkg::ACC_W-1:0]              rsp_pileup_total,
   // Register port
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [pfci_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [pfci_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [pfci_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);

   pfci_pkg::cfg_type  cfg_ff, cfg_in;
   pfci_pkg::qent_type q_wr_data, q_rd_data;
   logic [pfci_pkg::CSR_IDX_W-1:0] csr_idx;
   logic csr_wr, q_wr, q_full, q_valid, q_rd;

   assign pready  = 1'b1;
   assign csr_idx = paddr[pfci_pkg::CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            pfci_pkg::CSR_CONE:
               cfg_in.cone_dr2 = pwdata[pfci_pkg::DR2_W-1:0];
            pfci_pkg::CSR_CHG_VETO:
               cfg_in.charged_veto_dr2 = pwdata[pfci_pkg::DR2_W-1:0];
            pfci_pkg::CSR_NEU_VETO:
               cfg_in.neutral_veto_dr2 = pwdata[pfci_pkg::DR2_W-1:0];
            pfci_pkg::CSR_CHG_PT_MIN:
               cfg_in.charged_pt_min = pwdata[pfci_pkg::CUT_W-1:0];
            pfci_pkg::CSR_NEU_PT_MIN:
               cfg_in.neutral_pt_min = pwdata[pfci_pkg::CUT_W-1:0];
            pfci_pkg::CSR_PU_PT_MIN:
               cfg_in.pileup_pt_min = pwdata[pfci_pkg::CUT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read mux
   always_comb begin
      unique case (csr_idx)
         pfci_pkg::CSR_CONE:       prdata = pfci_pkg::CSR_DATA_W'(cfg_ff.cone_dr2);
         pfci_pkg::CSR_CHG_VETO:   prdata = pfci_pkg::CSR_DATA_W'(cfg_ff.charged_veto_dr2);
         pfci_pkg::CSR_NEU_VETO:   prdata = pfci_pkg::CSR_DATA_W'(cfg_ff.neutral_veto_dr2);
         pfci_pkg::CSR_CHG_PT_MIN: prdata = pfci_pkg::CSR_DATA_W'(cfg_ff.charged_pt_min);
         pfci_pkg::CSR_NEU_PT_MIN: prdata = pfci_pkg::CSR_DATA_W'(cfg_ff.neutral_pt_min);
         pfci_pkg::CSR_PU_PT_MIN:  prdata = pfci_pkg::CSR_DATA_W'(cfg_ff.pileup_pt_min);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cone_dr2         <= pfci_pkg::CONE_RST;
         cfg_ff.charged_veto_dr2 <= pfci_pkg::CHG_VETO_RST;
         cfg_ff.neutral_veto_dr2 <= pfci_pkg::NEU_VETO_RST;
         cfg_ff.charged_pt_min   <= pfci_pkg::CHG_MIN_RST;
         cfg_ff.neutral_pt_min   <= pfci_pkg::NEU_MIN_RST;
         cfg_ff.pileup_pt_min    <= pfci_pkg::PU_MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: distance and classification
   pfci_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .push            (push),
      .full            (full),
      .req_opcode      (req_opcode),
      .req_pt          (req_pt),
      .req_eta         (req_eta),
      .req_phi         (req_phi),
      .req_kind        (req_kind),
      .req_from_pileup (req_from_pileup),
      .req_last        (req_last),
      .q_full          (q_full),
      .q_wr            (q_wr),
      .q_wr_data       (q_wr_data)
   );

   // Queue between front and back
   pfci_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_en    (q_rd),
      .rd_data  (q_rd_data)
   );

   // Back: sums and result
   pfci_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_rd_data         (q_rd_data),
      .q_rd              (q_rd),
      .empty             (empty),
      .pop               (pop),
      .rsp_abs_iso       (rsp_abs_iso),
      .rsp_rel_iso       (rsp_rel_iso),
      .rsp_charged_total (rsp_charged_total),
      .rsp_neutral_total (rsp_neutral_total),
      .rsp_pileup_total  (rsp_pileup_total)
   );

endmodule
